// File: sv/bgi_pkg.sv
// shared types, constants and field layout of the bilinear grid interpolator
// depends on nothing; every other file of the block imports it
package bgi_pkg;

  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS    = 64;
  localparam int FRAC_BITS   = 16;

  localparam int VAL_W    = 32;
  localparam int SIZE_W   = 7;
  localparam int COL_W    = $clog2(MAX_COLUMNS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int AXI_W    = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int PROD_W   = 2 * (VAL_W + 1);
  localparam int POS_W    = 2 * VAL_W + 1 - FRAC_BITS;
  localparam int IDX_W    = POS_W - FRAC_BITS;
  localparam int FRAC_W   = POS_W + 1;
  localparam int LIM_SH   = 60;
  localparam int RES_W    = LIM_SH + 2;
  localparam int DA_W     = RES_W + 1;
  localparam int MA_W     = RES_W;
  localparam int MB_W     = FRAC_W;
  localparam int SPLIT    = 32;
  localparam int P_W      = MA_W + MB_W;
  localparam int MUL_LAT  = 4;

  localparam int NBANK      = 4;
  localparam int BANK_W     = 2;
  localparam int BA_W       = (COL_W - 1) + (ROW_W - 1);
  localparam int BANK_DEPTH = 1 << BA_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam int IN_TDATA_W  = 112;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 2;
  localparam int CFG_IDX_W   = 3;

  localparam logic signed [FRAC_W-1:0] ONE_FX = FRAC_W'(1 << FRAC_BITS);

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_VALUE   = 2'd1,
    CMD_SLOPE_X = 2'd2,
    CMD_SLOPE_Y = 2'd3
  } cmd_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_X_ORIGIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_ORIGIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_INV    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_INV    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS     = 3'd5;

  typedef struct packed {
    logic [VAL_W-1:0]  x_origin;
    logic [VAL_W-1:0]  y_origin;
    logic [VAL_W-1:0]  x_inv;
    logic [VAL_W-1:0]  y_inv;
    logic [SIZE_W-1:0] cols;
    logic [SIZE_W-1:0] rows;
  } cfg_t;

  // one classified item on its way to the table side
  typedef struct packed {
    cmd_t                     cmd;
    logic [AXI_W-1:0]         cl;
    logic [AXI_W-1:0]         cr;
    logic [AXI_W-1:0]         rb;
    logic [AXI_W-1:0]         rt;
    logic signed [FRAC_W-1:0] fx;
    logic signed [FRAC_W-1:0] fy;
    logic [VAL_W-1:0]         load_value;
  } q_entry_t;

endpackage

// File: sv/bgi_queue.sv
// short item queue between the front and the back of the interpolator
// depends on bgi_pkg
module bgi_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bgi_pkg::q_entry_t push_data,
  input  logic              pop,
  output bgi_pkg::q_entry_t pop_data,
  output logic              full,
  output logic              empty
);
  import bgi_pkg::*;

  q_entry_t            mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic [QCNT_W-1:0]   count_nxt;

  assign full     = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: sv/bgi_front.sv
// front of the interpolator: accepts items, maps coordinates onto the grid
// and hands classified items to the queue; depends on bgi_pkg
module bgi_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bgi_pkg::cfg_t               cfg,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  logic [1:0]                  item_cmd,
  input  logic                        item_clamp,
  input  logic [bgi_pkg::VAL_W-1:0]   item_x,
  input  logic [bgi_pkg::VAL_W-1:0]   item_y,
  input  logic [bgi_pkg::COL_W-1:0]   item_col,
  input  logic [bgi_pkg::ROW_W-1:0]   item_row,
  input  logic [bgi_pkg::VAL_W-1:0]   item_val,
  output logic                        push,
  output bgi_pkg::q_entry_t           push_data,
  input  logic                        q_full
);
  import bgi_pkg::*;

  typedef struct packed {
    logic [AXI_W-1:0]         lo;
    logic [AXI_W-1:0]         hi;
    logic signed [FRAC_W-1:0] frac;
  } axis_t;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] n, input int maxn);
    logic [SIZE_W-1:0] s;
    s = n;
    if (n < SIZE_W'(2)) begin
      s = SIZE_W'(2);
    end else if (n > SIZE_W'(maxn)) begin
      s = SIZE_W'(maxn);
    end
    return s;
  endfunction

  function automatic axis_t map_axis(input logic signed [POS_W-1:0] pos,
                                     input logic [SIZE_W-1:0] size,
                                     input logic clamp);
    logic signed [IDX_W-1:0]  idx;
    logic [SIZE_W-1:0]        lim;
    logic [AXI_W-1:0]         lo;
    logic [AXI_W-1:0]         hi;
    logic signed [FRAC_W-1:0] fr;
    axis_t                    a;
    idx = pos[POS_W-1:FRAC_BITS];
    lim = size - SIZE_W'(2);
    if (idx[IDX_W-1]) begin
      lo = '0;
    end else if (idx > $signed(IDX_W'(lim))) begin
      lo = lim[AXI_W-1:0];
    end else begin
      lo = idx[AXI_W-1:0];
    end
    hi = lo + 1'b1;
    fr = FRAC_W'(pos) - $signed(FRAC_W'({lo, FRAC_BITS'(0)}));
    if (clamp) begin
      // below the cell: collapse onto its lower edge; above: onto the last point
      if (fr < 0) begin
        fr = '0;
        hi = lo;
      end else if (fr > ONE_FX) begin
        fr = ONE_FX;
        lo = lim[AXI_W-1:0] + 1'b1;
        hi = lo;
      end
    end
    a.lo   = lo;
    a.hi   = hi;
    a.frac = fr;
    return a;
  endfunction

  logic                    fen;
  logic                    f1_valid_r;
  logic [1:0]              f1_cmd_r;
  logic                    f1_clamp_r;
  logic [VAL_W-1:0]        f1_x_r;
  logic [VAL_W-1:0]        f1_y_r;
  logic [COL_W-1:0]        f1_col_r;
  logic [ROW_W-1:0]        f1_row_r;
  logic [VAL_W-1:0]        f1_val_r;

  logic                    f2_valid_r;
  logic [1:0]              f2_cmd_r;
  logic                    f2_clamp_r;
  logic signed [POS_W-1:0] f2_xpos_r;
  logic signed [POS_W-1:0] f2_ypos_r;
  logic [COL_W-1:0]        f2_col_r;
  logic [ROW_W-1:0]        f2_row_r;
  logic [VAL_W-1:0]        f2_val_r;

  logic signed [VAL_W:0]    xd;
  logic signed [VAL_W:0]    yd;
  logic signed [VAL_W:0]    xi;
  logic signed [VAL_W:0]    yi;
  logic signed [PROD_W-1:0] xprod;
  logic signed [PROD_W-1:0] yprod;
  axis_t                    ax;
  axis_t                    ay;

  // the whole front moves together, held only by a full queue
  assign fen        = !f2_valid_r || !q_full;
  assign item_ready = fen;
  assign push       = f2_valid_r && !q_full;

  assign xd    = $signed({f1_x_r[VAL_W-1], f1_x_r}) -
                 $signed({cfg.x_origin[VAL_W-1], cfg.x_origin});
  assign yd    = $signed({f1_y_r[VAL_W-1], f1_y_r}) -
                 $signed({cfg.y_origin[VAL_W-1], cfg.y_origin});
  assign xi    = $signed({1'b0, cfg.x_inv});
  assign yi    = $signed({1'b0, cfg.y_inv});
  assign xprod = xd * xi;
  assign yprod = yd * yi;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
      f2_valid_r <= 1'b0;
    end else if (fen) begin
      f1_valid_r <= item_valid;
      f2_valid_r <= f1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      f1_cmd_r   <= item_cmd;
      f1_clamp_r <= item_clamp;
      f1_x_r     <= item_x;
      f1_y_r     <= item_y;
      f1_col_r   <= item_col;
      f1_row_r   <= item_row;
      f1_val_r   <= item_val;
      f2_cmd_r   <= f1_cmd_r;
      f2_clamp_r <= f1_clamp_r;
      f2_xpos_r  <= xprod[2*VAL_W:FRAC_BITS];
      f2_ypos_r  <= yprod[2*VAL_W:FRAC_BITS];
      f2_col_r   <= f1_col_r;
      f2_row_r   <= f1_row_r;
      f2_val_r   <= f1_val_r;
    end
  end

  assign ax = map_axis(f2_xpos_r, eff_size(cfg.cols, MAX_COLUMNS), f2_clamp_r);
  assign ay = map_axis(f2_ypos_r, eff_size(cfg.rows, MAX_ROWS), f2_clamp_r);

  always_comb begin
    push_data            = '0;
    push_data.cmd        = cmd_t'(f2_cmd_r);
    push_data.load_value = f2_val_r;
    if (cmd_t'(f2_cmd_r) == CMD_LOAD) begin
      // loads carry their table position in the lower-corner fields
      push_data.cl = AXI_W'(f2_col_r);
      push_data.rb = AXI_W'(f2_row_r);
    end else begin
      push_data.cl = ax.lo;
      push_data.cr = ax.hi;
      push_data.rb = ay.lo;
      push_data.rt = ay.hi;
      push_data.fx = ax.frac;
      push_data.fy = ay.frac;
    end
  end

endmodule

// File: sv/bgi_mulsh.sv
// pipelined signed multiply, floor shift by the fraction width and hold to
// plus or minus 2^60; four stages of 32-bit partial products; depends on bgi_pkg
module bgi_mulsh (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [bgi_pkg::DA_W-1:0]    a,
  input  logic signed [bgi_pkg::FRAC_W-1:0]  b,
  output logic signed [bgi_pkg::RES_W-1:0]   res
);
  import bgi_pkg::*;

  localparam logic [P_W-FRAC_BITS:0] LIM = (P_W - FRAC_BITS + 1)'(1) << LIM_SH;

  logic [MA_W-1:0]          ma_r;
  logic [MB_W-1:0]          mb_r;
  logic                     neg1_r;
  logic [2*SPLIT-1:0]       p00_r;
  logic [SPLIT+MB_W-SPLIT-1:0] p01_r;
  logic [MA_W-1:0]          p10_r;
  logic [P_W-2*SPLIT-1:0]   p11_r;
  logic                     neg2_r;
  logic [P_W-1:0]           sum_r;
  logic                     neg3_r;

  logic [DA_W-1:0]          abs_a;
  logic [FRAC_W-1:0]        abs_b;
  logic [P_W-FRAC_BITS:0]   q;
  logic [LIM_SH:0]          mag;

  assign abs_a = a[DA_W-1] ? -a : a;
  assign abs_b = b[FRAC_W-1] ? -b : b;

  always_comb begin
    q = (P_W - FRAC_BITS + 1)'(sum_r[P_W-1:FRAC_BITS]) +
        (P_W - FRAC_BITS + 1)'(neg3_r && (sum_r[FRAC_BITS-1:0] != '0));
    mag = (q > LIM) ? LIM[LIM_SH:0] : q[LIM_SH:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r   <= abs_a[MA_W-1:0];
      mb_r   <= abs_b[MB_W-1:0];
      neg1_r <= a[DA_W-1] ^ b[FRAC_W-1];
      p00_r  <= ma_r[SPLIT-1:0] * mb_r[SPLIT-1:0];
      p01_r  <= ma_r[SPLIT-1:0] * mb_r[MB_W-1:SPLIT];
      p10_r  <= ma_r[MA_W-1:SPLIT] * mb_r[SPLIT-1:0];
      p11_r  <= ma_r[MA_W-1:SPLIT] * mb_r[MB_W-1:SPLIT];
      neg2_r <= neg1_r;
      sum_r  <= P_W'(p00_r) + (P_W'(p01_r) << SPLIT) + (P_W'(p10_r) << SPLIT) +
                (P_W'(p11_r) << (2 * SPLIT));
      neg3_r <= neg2_r;
      res    <= neg3_r ? -$signed(RES_W'(mag)) : $signed(RES_W'(mag));
    end
  end

endmodule

// File: sv/bgi_back.sv
// back of the interpolator: banked value table, two lerp passes and the
// result register; depends on bgi_pkg and bgi_mulsh
module bgi_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bgi_pkg::cfg_t                     cfg,
  input  logic                              q_empty,
  input  bgi_pkg::q_entry_t                 q_data,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bgi_pkg::VAL_W-1:0]         out_value,
  output logic [1:0]                        out_status
);
  import bgi_pkg::*;

  typedef struct packed {
    cmd_t                     cmd;
    logic                     cl0;
    logic                     cr0;
    logic                     rb0;
    logic                     rt0;
    logic signed [FRAC_W-1:0] fx;
    logic signed [FRAC_W-1:0] fy;
  } s1_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic signed [FRAC_W-1:0] fy;
    logic signed [VAL_W-1:0]  la0;
    logic signed [VAL_W-1:0]  la1;
  } d_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic signed [FRAC_W-1:0] fy;
    logic signed [RES_W-1:0]  lo1;
    logic signed [RES_W-1:0]  hi1;
  } s2_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic signed [RES_W-1:0]  base;
  } e_t;

  localparam logic signed [DA_W-1:0] LIM_HI = DA_W'(1) <<< LIM_SH;
  localparam logic signed [DA_W-1:0] LIM_LO = -LIM_HI;
  localparam logic signed [DA_W-1:0] I32_HI = DA_W'(2**(VAL_W-1) - 1);
  localparam logic signed [DA_W-1:0] I32_LO = -I32_HI - DA_W'(1);

  function automatic logic signed [RES_W-1:0] clamp60(input logic signed [DA_W-1:0] v);
    logic signed [DA_W-1:0] c;
    c = v;
    if (v > LIM_HI) begin
      c = LIM_HI;
    end else if (v < LIM_LO) begin
      c = LIM_LO;
    end
    return c[RES_W-1:0];
  endfunction

  logic en;

  logic [VAL_W-1:0]  bank_mem [NBANK][BANK_DEPTH];
  logic [VAL_W-1:0]  rd_r [NBANK];
  logic [BA_W-1:0]   raddr [NBANK];
  logic [BANK_W-1:0] wbank;
  logic [BA_W-1:0]   waddr;
  logic              wr;

  logic              s1_valid_r;
  s1_t               s1_r;
  logic [MUL_LAT-1:0] dv_r;
  d_t                d_r [MUL_LAT];
  logic              s2_valid_r;
  s2_t               s2_r;
  logic [MUL_LAT-1:0] ev_r;
  e_t                e_r [MUL_LAT];
  logic              out_valid_r;
  logic [VAL_W-1:0]  out_value_r;
  logic [1:0]        out_status_r;

  logic signed [VAL_W-1:0]  e00, e10, e01, e11;
  logic signed [VAL_W-1:0]  la0, lb0, la1, lb1;
  logic signed [FRAC_W-1:0] f1;
  logic signed [DA_W-1:0]   m0_a, m1_a, m2_a;
  logic signed [FRAC_W-1:0] m2_b;
  logic signed [RES_W-1:0]  m0, m1, m2;
  logic signed [RES_W-1:0]  base2;
  logic signed [DA_W-1:0]   r;
  logic [VAL_W-1:0]         r_val;
  logic [1:0]               r_st;
  d_t                       d_in;
  e_t                       e_in;

  // the whole back advances while the result register can move
  assign en    = !out_valid_r || out_ready;
  assign q_pop = en && !q_empty;

  assign wr    = q_pop && (q_data.cmd == CMD_LOAD);
  assign wbank = {q_data.cl[0], q_data.rb[0]};
  assign waddr = {q_data.cl[COL_W-1:1], q_data.rb[ROW_W-1:1]};

  // bank {p,q} holds columns of parity p and rows of parity q
  always_comb begin
    logic [AXI_W-1:0] csel;
    logic [AXI_W-1:0] rsel;
    for (int b = 0; b < NBANK; b++) begin
      csel = (q_data.cl[0] == 1'(b >> 1)) ? q_data.cl : q_data.cr;
      rsel = (q_data.rb[0] == 1'(b)) ? q_data.rb : q_data.rt;
      raddr[b] = {csel[COL_W-1:1], rsel[ROW_W-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < NBANK; b++) begin
      if (wr && (wbank == BANK_W'(b))) begin
        bank_mem[b][waddr] <= q_data.load_value;
      end
      if (en) begin
        rd_r[b] <= bank_mem[b][raddr[b]];
      end
    end
  end

  // first pass: two lerps, along x for value and slope y, along y for slope x
  always_comb begin
    e00 = rd_r[{s1_r.cl0, s1_r.rb0}];
    e10 = rd_r[{s1_r.cr0, s1_r.rb0}];
    e01 = rd_r[{s1_r.cl0, s1_r.rt0}];
    e11 = rd_r[{s1_r.cr0, s1_r.rt0}];
    if (s1_r.cmd == CMD_SLOPE_X) begin
      la0 = e00;
      lb0 = e01;
      la1 = e10;
      lb1 = e11;
      f1  = s1_r.fy;
    end else begin
      la0 = e00;
      lb0 = e10;
      la1 = e01;
      lb1 = e11;
      f1  = s1_r.fx;
    end
    m0_a = DA_W'(lb0) - DA_W'(la0);
    m1_a = DA_W'(lb1) - DA_W'(la1);
    d_in.cmd = s1_r.cmd;
    d_in.fy  = s1_r.fy;
    d_in.la0 = la0;
    d_in.la1 = la1;
  end

  bgi_mulsh u_mul0 (.clk(clk), .en(en), .a(m0_a), .b(f1), .res(m0));
  bgi_mulsh u_mul1 (.clk(clk), .en(en), .a(m1_a), .b(f1), .res(m1));

  // second pass: lerp along y, or the difference scaled by the step reciprocal
  always_comb begin
    m2_a = DA_W'(s2_r.hi1) - DA_W'(s2_r.lo1);
    case (s2_r.cmd)
      CMD_VALUE:   m2_b = s2_r.fy;
      CMD_SLOPE_X: m2_b = $signed(FRAC_W'(cfg.x_inv));
      CMD_SLOPE_Y: m2_b = $signed(FRAC_W'(cfg.y_inv));
      default:     m2_b = '0;
    endcase
    base2    = (s2_r.cmd == CMD_VALUE) ? s2_r.lo1 : '0;
    e_in.cmd  = s2_r.cmd;
    e_in.base = base2;
  end

  bgi_mulsh u_mul2 (.clk(clk), .en(en), .a(m2_a), .b(m2_b), .res(m2));

  always_comb begin
    r     = DA_W'(e_r[MUL_LAT-1].base) + DA_W'(m2);
    r_val = r[VAL_W-1:0];
    r_st  = ST_OK;
    if (e_r[MUL_LAT-1].cmd == CMD_LOAD) begin
      r_val = '0;
      r_st  = ST_LOAD;
    end else if (r > I32_HI) begin
      r_val = I32_HI[VAL_W-1:0];
      r_st  = ST_SAT;
    end else if (r < I32_LO) begin
      r_val = I32_LO[VAL_W-1:0];
      r_st  = ST_SAT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      dv_r        <= '0;
      s2_valid_r  <= 1'b0;
      ev_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= q_pop;
      dv_r        <= {dv_r[MUL_LAT-2:0], s1_valid_r};
      s2_valid_r  <= dv_r[MUL_LAT-1];
      ev_r        <= {ev_r[MUL_LAT-2:0], s2_valid_r};
      out_valid_r <= ev_r[MUL_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r.cmd <= q_data.cmd;
      s1_r.cl0 <= q_data.cl[0];
      s1_r.cr0 <= q_data.cr[0];
      s1_r.rb0 <= q_data.rb[0];
      s1_r.rt0 <= q_data.rt[0];
      s1_r.fx  <= q_data.fx;
      s1_r.fy  <= q_data.fy;
      d_r[0]   <= d_in;
      for (int i = 1; i < MUL_LAT; i++) begin
        d_r[i] <= d_r[i-1];
      end
      s2_r.cmd <= d_r[MUL_LAT-1].cmd;
      s2_r.fy  <= d_r[MUL_LAT-1].fy;
      s2_r.lo1 <= clamp60(DA_W'(d_r[MUL_LAT-1].la0) + DA_W'(m0));
      s2_r.hi1 <= clamp60(DA_W'(d_r[MUL_LAT-1].la1) + DA_W'(m1));
      e_r[0]   <= e_in;
      for (int i = 1; i < MUL_LAT; i++) begin
        e_r[i] <= e_r[i-1];
      end
      out_value_r  <= r_val;
      out_status_r <= r_st;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule

// File: sv/bilinear_grid_interpolator.sv
// top level of the bilinear grid interpolator: configuration registers,
// front, queue and back; depends on bgi_pkg, bgi_front, bgi_queue, bgi_back
//
//   channel  | direction | contents
//   ---------+-----------+----------------------------------------------
//   in_*     | input     | tdata x, y, load column, load row, load value
//            |           | tuser command, clamp mode
//   out_*    | output    | tdata result value; tuser status
//   cfg_*    | input     | write enable, register index, write data
//
// one item per cycle sustained while results are taken; each accepted item
// passes two front stages, the queue, the table read, then two lerp
// passes of 4-stage multipliers and the result register
// reset clears the registers to their defaults and empties all stages;
// table contents are undefined until loaded
// a stalled result holds the back; front accepts until the 4-entry queue fills
module bilinear_grid_interpolator (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // x[31:0], y[63:32], load_column[69:64], load_row[75:70], load_value[107:76]
  input  logic [bgi_pkg::IN_TDATA_W-1:0]        in_tdata,
  // command[1:0], clamp_mode[2]
  input  logic [bgi_pkg::IN_TUSER_W-1:0]        in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // result_value[31:0]
  output logic [bgi_pkg::OUT_TDATA_W-1:0]       out_tdata,
  // status[1:0]
  output logic [bgi_pkg::OUT_TUSER_W-1:0]       out_tuser,
  input  logic                                  cfg_we,
  input  logic [bgi_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [bgi_pkg::VAL_W-1:0]             cfg_data
);
  import bgi_pkg::*;

  cfg_t      cfg_r;
  logic      push;
  q_entry_t  push_data;
  logic      q_full;
  logic      q_empty;
  logic      q_pop;
  q_entry_t  q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_origin <= '0;
      cfg_r.y_origin <= '0;
      cfg_r.x_inv    <= VAL_W'(1 << FRAC_BITS);
      cfg_r.y_inv    <= VAL_W'(1 << FRAC_BITS);
      cfg_r.cols     <= SIZE_W'(2);
      cfg_r.rows     <= SIZE_W'(2);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_X_ORIGIN: cfg_r.x_origin <= cfg_data;
        CFG_Y_ORIGIN: cfg_r.y_origin <= cfg_data;
        CFG_X_INV:    cfg_r.x_inv    <= cfg_data;
        CFG_Y_INV:    cfg_r.y_inv    <= cfg_data;
        CFG_COLS:     cfg_r.cols     <= cfg_data[SIZE_W-1:0];
        CFG_ROWS:     cfg_r.rows     <= cfg_data[SIZE_W-1:0];
        default:      ;
      endcase
    end
  end

  bgi_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (in_tvalid),
    .item_ready (in_tready),
    .item_cmd   (in_tuser[1:0]),
    .item_clamp (in_tuser[2]),
    .item_x     (in_tdata[31:0]),
    .item_y     (in_tdata[63:32]),
    .item_col   (in_tdata[69:64]),
    .item_row   (in_tdata[75:70]),
    .item_val   (in_tdata[107:76]),
    .push       (push),
    .push_data  (push_data),
    .q_full     (q_full)
  );

  bgi_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (q_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  bgi_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_value  (out_tdata),
    .out_status (out_tuser)
  );

endmodule

// File: bench/tb_top.sv
// self-checking bench for bilinear_grid_interpolator: a directed table, then phases of random
// loads and queries under several register settings, each checked against the typed
// result or an in-bench predictor; depends on bgi_pkg and the block's top level
module tb_top;
  import bgi_pkg::*;

  localparam longint LIM60 = 64'sd1 <<< 60;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG = 3000;
  localparam int NPHASE = 10;
  localparam int PER_PHASE = 135;

  // register indexes beyond the listed ones, written to check they are ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct {
    cmd_t        cmd;
    logic [31:0] x;
    logic [31:0] y;
    logic        clamp;
    logic [5:0]  col;
    logic [5:0]  row;
    logic [31:0] val;
    bit          typed;
    logic [31:0] t_res;
    logic [1:0]  t_st;
  } item_t;

  typedef struct {
    logic [31:0] res;
    logic [1:0]  st;
  } result_t;

  logic clk = 0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic [IN_TUSER_W-1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [VAL_W-1:0] cfg_data;

  bilinear_grid_interpolator u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // predictor copy of the registers and the value grid
  logic [31:0] g_x_org, g_y_org, g_x_inv, g_y_inv;
  logic [6:0]  g_cols, g_rows;
  logic signed [31:0] grid_vals [64][64];
  bit          grid_written [64][64];

  result_t pending_results[$];
  item_t   stim_rows[$];
  int errors = 0;
  int n_loads = 0, n_queries = 0, n_sat = 0, n_checked = 0;
  int burst_left = 0;
  bit gapless = 0;
  bit hold_req = 0;
  int idle_cycles = 0;

  task automatic report(input string msg);
    if (errors < 40) $display("mismatch: %s", msg);
    errors++;
  endtask

  task automatic add_row(input item_t it);
    stim_rows.insert(stim_rows.size(), it);
  endtask

  // floor(a*b / 2^FRAC_BITS), held to +-2^60
  function automatic longint mul_floor(input longint a, input longint b);
    logic signed [127:0] pa, pb, p;
    pa = a;
    pb = b;
    p = (pa * pb) >>> FRAC_BITS;
    if (p > LIM60) return LIM60;
    if (p < -LIM60) return -LIM60;
    return p[63:0];
  endfunction

  function automatic longint hold60(input longint v);
    if (v > LIM60) return LIM60;
    if (v < -LIM60) return -LIM60;
    return v;
  endfunction

  function automatic longint blend(input longint a, input longint b, input longint f);
    return hold60(a + mul_floor(b - a, f));
  endfunction

  function automatic int grid_size(input logic [6:0] n, input int maxn);
    if (n < 2) return 2;
    if (n > maxn) return maxn;
    return n;
  endfunction

  task automatic locate(input logic [31:0] coord, input logic [31:0] org,
                        input logic [31:0] inv, input int size, input logic clamp,
                        output int lo, output int hi, output longint frac);
    longint pos, idx;
    pos = mul_floor(longint'($signed(coord)) - longint'($signed(org)),
                    longint'({32'b0, inv}));
    idx = pos >>> FRAC_BITS;
    if (idx < 0) idx = 0;
    if (idx > size - 2) idx = size - 2;
    lo = int'(idx);
    hi = int'(idx) + 1;
    frac = pos - (idx <<< FRAC_BITS);
    if (clamp) begin
      // outside the grid the cell collapses onto its edge
      if (frac < 0) begin
        frac = 0;
        hi = lo;
      end else if (frac > (64'sd1 <<< FRAC_BITS)) begin
        frac = 64'sd1 <<< FRAC_BITS;
        lo = size - 1;
        hi = size - 1;
      end
    end
  endtask

  task automatic predict_result(input item_t it, output result_t r);
    int cl, cr, rb, rt;
    longint fx, fy, v, lo_part, hi_part;
    r.st = ST_OK;
    if (it.cmd == CMD_LOAD) begin
      grid_vals[it.col][it.row] = it.val;
      grid_written[it.col][it.row] = 1;
      r.res = 0;
      r.st = ST_LOAD;
      return;
    end
    locate(it.x, g_x_org, g_x_inv, grid_size(g_cols, MAX_COLUMNS), it.clamp, cl, cr, fx);
    locate(it.y, g_y_org, g_y_inv, grid_size(g_rows, MAX_ROWS), it.clamp, rb, rt, fy);
    if (it.cmd == CMD_SLOPE_X) begin
      lo_part = blend(grid_vals[cl][rb], grid_vals[cl][rt], fy);
      hi_part = blend(grid_vals[cr][rb], grid_vals[cr][rt], fy);
      v = mul_floor(hi_part - lo_part, longint'({32'b0, g_x_inv}));
    end else begin
      lo_part = blend(grid_vals[cl][rb], grid_vals[cr][rb], fx);
      hi_part = blend(grid_vals[cl][rt], grid_vals[cr][rt], fx);
      if (it.cmd == CMD_VALUE) v = blend(lo_part, hi_part, fy);
      else v = mul_floor(hi_part - lo_part, longint'({32'b0, g_y_inv}));
    end
    if (v > 64'sd2147483647) begin
      v = 64'sd2147483647;
      r.st = ST_SAT;
    end
    if (v < -64'sd2147483648) begin
      v = -64'sd2147483648;
      r.st = ST_SAT;
    end
    r.res = v[31:0];
  endtask

  // sender: bursts of items with random gaps, unless in a gapless stretch
  task automatic send_item(input item_t it);
    result_t r;
    if (burst_left == 0) begin
      if (!gapless) begin
        in_tvalid = 0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tdata = {4'b0, it.val, it.row, it.col, it.y, it.x};
    in_tuser = {it.clamp, it.cmd};
    in_tvalid = 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_result(it, r);
    if (it.typed) begin
      r.res = it.t_res;
      r.st = it.t_st;
    end
    pending_results.insert(pending_results.size(), r);
    if (it.cmd == CMD_LOAD) n_loads++;
    else n_queries++;
    @(negedge clk);
    burst_left--;
  endtask

  task automatic drain;
    in_tvalid = 0;
    burst_left = 0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 0;
    case (idx)
      CFG_X_ORIGIN: g_x_org = data;
      CFG_Y_ORIGIN: g_y_org = data;
      CFG_X_INV:    g_x_inv = data;
      CFG_Y_INV:    g_y_inv = data;
      CFG_COLS:     g_cols = data[6:0];
      CFG_ROWS:     g_rows = data[6:0];
      default: ;
    endcase
  endtask

  function automatic item_t mk(input cmd_t c, input logic [31:0] x, input logic [31:0] y,
                               input logic cm, input int col, input int row,
                               input logic [31:0] val, input bit typed,
                               input logic [31:0] t_res, input logic [1:0] t_st);
    item_t it;
    it.cmd = c;
    it.x = x;
    it.y = y;
    it.clamp = cm;
    it.col = 6'(col);
    it.row = 6'(row);
    it.val = val;
    it.typed = typed;
    it.t_res = t_res;
    it.t_st = t_st;
    return it;
  endfunction

  function automatic logic [31:0] rand_value();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return 32'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
  endfunction

  // a coordinate near the grid, or anywhere at all
  function automatic logic [31:0] rand_coord(input logic [31:0] org, input logic [31:0] inv,
                                             input int size);
    longint p;
    if ($urandom_range(0, 9) < 4 || inv == 0) return $urandom;
    p = longint'($urandom_range(0, (size + 3) * 65536)) - 2 * 65536;
    return 32'(longint'($signed(org)) + (p * 65536) / longint'({32'b0, inv}));
  endfunction

  function automatic item_t rand_item();
    item_t it;
    it.typed = 0;
    it.col = 6'($urandom_range(0, 63));
    it.row = 6'($urandom_range(0, 63));
    it.val = rand_value();
    it.clamp = 1'($urandom_range(0, 1));
    it.cmd = ($urandom_range(0, 99) < 15) ? CMD_LOAD : cmd_t'($urandom_range(1, 3));
    it.x = rand_coord(g_x_org, g_x_inv, grid_size(g_cols, MAX_COLUMNS));
    it.y = rand_coord(g_y_org, g_y_inv, grid_size(g_rows, MAX_ROWS));
    return it;
  endfunction

  // result checker
  always @(posedge clk) begin
    result_t e;
    if (out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result %h status %0d", out_tdata, out_tuser));
      end else begin
        e = pending_results.pop_front();
        n_checked++;
        if (out_tuser == ST_SAT) n_sat++;
        if (out_tdata !== e.res)
          report($sformatf("value %h, expected %h", out_tdata, e.res));
        if (out_tuser !== e.st)
          report($sformatf("status %0d, expected %0d", out_tuser, e.st));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG) begin
      $display("timeout: no item moved for %0d cycles", WATCHDOG);
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: its own stall pattern, plus one long hold on request
  initial begin
    int cyc;
    int mode;
    cyc = 0;
    out_tready = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_req) begin
        out_tready = 0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 0;
      end else begin
        mode = (cyc / 150) % 3;
        case (mode)
          0: out_tready = 1;
          1: out_tready = $urandom_range(0, 1);
          default: out_tready = ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  initial begin
    logic [31:0] xo, yo, xi, yi, cdat, rdat;
    int cols, rows;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    g_x_org = 0;
    g_y_org = 0;
    g_x_inv = 32'h0001_0000;
    g_y_inv = 32'h0001_0000;
    g_cols = 2;
    g_rows = 2;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // defaults after reset: 2x2 grid at the origin, unit spacing
    add_row(mk(CMD_LOAD, 0, 0, 0, 0, 0, 32'h0001_0000, 1, 0, ST_LOAD));
    add_row(mk(CMD_LOAD, 0, 0, 0, 1, 0, 32'h0002_0000, 1, 0, ST_LOAD));
    add_row(mk(CMD_LOAD, 0, 0, 0, 0, 1, 32'h0003_0000, 1, 0, ST_LOAD));
    add_row(mk(CMD_LOAD, 0, 0, 0, 1, 1, 32'h0004_0000, 1, 0, ST_LOAD));
    add_row(mk(CMD_VALUE, 0, 0, 0, 0, 0, 0, 1, 32'h0001_0000, ST_OK));
    add_row(mk(CMD_VALUE, 32'h1_0000, 32'h1_0000, 0, 0, 0, 0, 1,
               32'h0004_0000, ST_OK));
    add_row(mk(CMD_VALUE, 32'h8000, 32'h8000, 0, 0, 0, 0, 1, 32'h0002_8000, ST_OK));
    add_row(mk(CMD_SLOPE_X, 32'h8000, 32'h8000, 0, 0, 0, 0, 1,
               32'h0001_0000, ST_OK));
    add_row(mk(CMD_SLOPE_Y, 32'h8000, 32'h8000, 0, 0, 0, 0, 1,
               32'h0002_0000, ST_OK));
    // outside the grid: linear extension, then edge hold
    add_row(mk(CMD_VALUE, 32'h2_0000, 0, 0, 0, 0, 0, 1, 32'h0003_0000, ST_OK));
    add_row(mk(CMD_VALUE, 32'h2_0000, 0, 1, 0, 0, 0, 1, 32'h0002_0000, ST_OK));
    add_row(mk(CMD_VALUE, 32'hFFFF_0000, 0, 1, 0, 0, 0, 1, 32'h0001_0000, ST_OK));
    add_row(mk(CMD_SLOPE_X, 32'h2_0000, 0, 1, 0, 0, 0, 1, 0, ST_OK));
    add_row(mk(CMD_SLOPE_Y, 0, 32'hFFFF_0000, 1, 0, 0, 0, 1, 0, ST_OK));
    // extreme values and saturation both ways
    add_row(mk(CMD_LOAD, 0, 0, 0, 63, 63, 32'h7FFF_FFFF, 1, 0, ST_LOAD));
    add_row(mk(CMD_LOAD, 0, 0, 0, 0, 0, 32'h8000_0000, 1, 0, ST_LOAD));
    add_row(mk(CMD_LOAD, 0, 0, 0, 1, 0, 32'h7FFF_FFFF, 1, 0, ST_LOAD));
    add_row(mk(CMD_VALUE, 0, 0, 0, 0, 0, 0, 1, 32'h8000_0000, ST_OK));
    add_row(mk(CMD_VALUE, 32'h2_0000, 0, 0, 0, 0, 0, 1, 32'h7FFF_FFFF, ST_SAT));
    add_row(mk(CMD_VALUE, 32'hFFFF_0000, 0, 0, 0, 0, 0, 1, 32'h8000_0000, ST_SAT));
    add_row(mk(CMD_SLOPE_X, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk(CMD_SLOPE_Y, 32'h8000_0000, 32'h7FFF_FFFF, 1, 0, 0, 0, 0, 0, 0));
    add_row(mk(CMD_VALUE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0, 0, 0, 0, 0, 0));
    add_row(mk(CMD_LOAD, 0, 0, 0, 42, 21, 32'h5A5A_5A5A, 1, 0, ST_LOAD));
    foreach (stim_rows[i]) send_item(stim_rows[i]);

    for (int ph = 0; ph < NPHASE; ph++) begin
      drain();
      gapless = (ph % 3 == 1);
      xo = 32'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
      yo = 32'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
      xi = $urandom_range(1 << 12, 1 << 20);
      yi = $urandom_range(1 << 12, 1 << 20);
      cols = $urandom_range(2, 8);
      rows = $urandom_range(2, 8);
      case (ph)
        1: begin
          cols = 127;
          rows = 0;
          xo = 32'h8000_0000;
        end
        2: begin
          cols = 2;
          rows = 64;
          xi = 32'hFFFF_FFFF;
          yi = 1;
          yo = 32'h7FFF_FFFF;
        end
        3: begin
          xi = 0;
          yi = 0;
        end
        4: begin
          cols = 1;
          rows = 65;
        end
        default: ;
      endcase
      // register upper bits beyond the size field are don't-care
      cdat = 32'({$urandom, 7'(cols)});
      rdat = 32'({$urandom, 7'(rows)});
      cfg_write(CFG_X_ORIGIN, xo);
      cfg_write(CFG_Y_ORIGIN, yo);
      cfg_write(CFG_X_INV, xi);
      cfg_write(CFG_Y_INV, yi);
      cfg_write(CFG_COLS, cdat);
      cfg_write(CFG_ROWS, rdat);
      if (ph == 4) begin
        cfg_write(CFG_SPARE_LO, $urandom);
        cfg_write(CFG_SPARE_HI, $urandom);
      end
      // every entry a query can reach must be loaded first
      for (int c = 0; c < grid_size(g_cols, MAX_COLUMNS); c++)
        for (int r = 0; r < grid_size(g_rows, MAX_ROWS); r++)
          if (!grid_written[c][r])
            send_item(mk(CMD_LOAD, $urandom, $urandom, $urandom_range(0, 1), c, r,
                         rand_value(), 0, 0, 0));
      for (int n = 0; n < PER_PHASE; n++) begin
        if (ph == 5 && n == 40) hold_req = 1;
        send_item(rand_item());
      end
    end

    drain();
    repeat (30) @(negedge clk);
    if (pending_results.size() != 0)
      report($sformatf("%0d results never arrived", pending_results.size()));
    $display("covered %0d loads and %0d queries over %0d register settings",
             n_loads, n_queries, NPHASE + 1);
    $display("%0d results checked, %0d of them saturated", n_checked, n_sat);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: bilinear_grid_interpolator.f
sv/bgi_pkg.sv
sv/bgi_queue.sv
sv/bgi_front.sv
sv/bgi_mulsh.sv
sv/bgi_back.sv
sv/bilinear_grid_interpolator.sv
bench/tb_top.sv
